[hw/rtl/ignition_key_debounce_detector_macros.svh]
// assertion helpers used by ignition_key_debounce_detector.sv
`ifndef IGNITION_KEY_DEBOUNCE_DETECTOR_MACROS_SVH
`define IGNITION_KEY_DEBOUNCE_DETECTOR_MACROS_SVH

// same-cycle implication
`define IKD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ikd_pkg.sv]
`default_nettype none

package ikd_pkg;

    localparam int EVENT_DEPTH = 4;
    localparam int EVT_IDX_W   = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 1'd1;

    localparam logic [7:0] FILTER_TIME_RESET = 8'd5;
    localparam logic [7:0] SCAN_PERIOD_RESET = 8'd10;

    typedef logic [EVT_IDX_W-1:0] evt_idx_t;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_VALID   = 2'd1,
        EVT_INVALID = 2'd2
    } evt_t;

    typedef struct packed {
        logic key_on;
        logic arm_rising;
        logic state_changed;
        logic irq_pending;
    } ikd_result_t;

    function automatic evt_idx_t evt_next(input evt_idx_t idx);
        evt_idx_t res;
        if (idx == evt_idx_t'(EVENT_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + evt_idx_t'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ikd_core.sv]
`default_nettype none

module ikd_core
    import ikd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  step,
    input  wire logic                  pin_level,
    input  wire logic                  edge_irq,
    output ikd_result_t                result
);

    logic [7:0] filter_time_reg;
    logic [7:0] scan_period_reg;

    logic       key_state_reg,      key_state_next;
    logic       irq_flag_reg,       irq_flag_next;
    logic [7:0] prescale_count_reg, prescale_count_next;
    logic [7:0] on_count_reg,       on_count_next;
    logic [7:0] off_count_reg,      off_count_next;
    logic       token_free_reg,     token_free_next;
    evt_t       event_store_reg  [EVENT_DEPTH];
    evt_t       event_store_next [EVENT_DEPTH];
    evt_idx_t   write_index_reg,    write_index_next;
    evt_idx_t   read_index_reg,     read_index_next;

    logic       changed;
    evt_t       code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_time_reg <= FILTER_TIME_RESET;
            scan_period_reg <= SCAN_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_TIME: filter_time_reg <= cfg_data;
                CFG_SCAN_PERIOD: scan_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // order within a tick: latch flag, prescale and scan, then consume
    always_comb
    begin
        key_state_next      = key_state_reg;
        irq_flag_next       = irq_flag_reg | edge_irq;
        prescale_count_next = prescale_count_reg;
        on_count_next       = on_count_reg;
        off_count_next      = off_count_reg;
        token_free_next     = token_free_reg;
        event_store_next    = event_store_reg;
        write_index_next    = write_index_reg;
        read_index_next     = read_index_reg;
        changed             = 1'b0;
        code                = EVT_NONE;

        if (irq_flag_next)
        begin
            prescale_count_next = prescale_count_reg + 8'd1;
            if (prescale_count_next >= scan_period_reg)
            begin
                prescale_count_next = '0;
                if (!pin_level)
                begin
                    off_count_next = '0;
                    if (on_count_reg < filter_time_reg)
                    begin
                        on_count_next = on_count_reg + 8'd1;
                    end
                    else if (token_free_reg)
                    begin
                        token_free_next = 1'b0;
                        event_store_next[write_index_reg] = EVT_VALID;
                        write_index_next = evt_next(write_index_reg);
                    end
                end
                else
                begin
                    on_count_next = '0;
                    if (off_count_reg < filter_time_reg)
                    begin
                        off_count_next = off_count_reg + 8'd1;
                    end
                    else if (token_free_reg)
                    begin
                        token_free_next = 1'b0;
                        event_store_next[write_index_reg] = EVT_INVALID;
                        write_index_next = evt_next(write_index_reg);
                    end
                end
            end
        end

        // a beat pushed this tick is visible to the consume step
        if (irq_flag_next && (read_index_reg != write_index_next))
        begin
            code = event_store_next[read_index_reg];
            event_store_next[read_index_reg] = EVT_NONE;
            read_index_next = evt_next(read_index_reg);
            if (!key_state_reg && (code == EVT_VALID))
            begin
                key_state_next = 1'b1;
                changed        = 1'b1;
            end
            else if (key_state_reg && (code == EVT_INVALID))
            begin
                key_state_next = 1'b0;
                changed        = 1'b1;
            end
            token_free_next = 1'b1;
            irq_flag_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_state_reg      <= 1'b0;
            irq_flag_reg       <= 1'b0;
            prescale_count_reg <= '0;
            on_count_reg       <= '0;
            off_count_reg      <= '0;
            token_free_reg     <= 1'b1;
            for (int i = 0; i < EVENT_DEPTH; i++)
            begin
                event_store_reg[i] <= EVT_NONE;
            end
            write_index_reg    <= '0;
            read_index_reg     <= '0;
        end
        else if (step)
        begin
            key_state_reg      <= key_state_next;
            irq_flag_reg       <= irq_flag_next;
            prescale_count_reg <= prescale_count_next;
            on_count_reg       <= on_count_next;
            off_count_reg      <= off_count_next;
            token_free_reg     <= token_free_next;
            event_store_reg    <= event_store_next;
            write_index_reg    <= write_index_next;
            read_index_reg     <= read_index_next;
        end
    end

    assign result.key_on        = key_state_next;
    assign result.arm_rising    = key_state_next;
    assign result.state_changed = changed;
    assign result.irq_pending   = irq_flag_next;

endmodule

`default_nettype wire

[hw/rtl/ignition_key_debounce_detector.sv]
`default_nettype none

// Ignition key debounce filter. Each input beat is one timer tick carrying the raw
// active-low key pin and the edge-interrupt flag; each tick yields exactly one result
// beat with the debounced key state, the edge to arm next, a toggle strobe and whether
// the interrupt flag is still pending. One tick is taken per cycle while in_ready is
// high: the whole state update (prescaler, saturating on/off counters, four-entry
// event ring and key state) is combinational; the result appears in an output register
// in the cycle after the tick is accepted. in_ready stays high while that register is
// empty or is being drained in the same cycle. Write filter_time and scan_period
// through the cfg port only while no tick is in flight; the block does not enforce it.

`include "ignition_key_debounce_detector_macros.svh"

module ignition_key_debounce_detector
    import ikd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  pin_level,
    input  wire logic                  edge_irq,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       key_on,
    output logic                       arm_rising,
    output logic                       state_changed,
    output logic                       irq_pending
);

    logic        out_valid_reg;
    ikd_result_t res_reg;
    ikd_result_t res_next;
    logic        step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    ikd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .pin_level (pin_level),
        .edge_irq  (edge_irq),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_on        = res_reg.key_on;
    assign arm_rising    = res_reg.arm_rising;
    assign state_changed = res_reg.state_changed;
    assign irq_pending   = res_reg.irq_pending;

    `IKD_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, in_ready,
        "input stalled while result register empty")

    `IKD_ASSERT_NEXT(a_result_follows_tick, step, out_valid_reg,
        "accepted tick produced no result")

    `IKD_ASSERT_NOW(a_toggle_clears_flag, out_valid_reg && res_reg.state_changed,
        !res_reg.irq_pending, "key toggled but interrupt flag still set")

endmodule

`default_nettype wire
